// ===== rtl/pse_pkg.sv =====
// Shared types and constants for the prime sieve engine.
// Request and response payloads, status codes, controller states and the
// command/status bundles between controller and datapath. No dependencies.
package pse_pkg;

   // Default for the highest limit the bitmap is sized for
   localparam int LIMIT_MAX_DEFAULT = 65535;
   // Highest index a 16-bit query can name
   localparam int INDEX_MAX = 65535;
   // Limit register value after reset
   localparam logic [15:0] SIEVE_LIMIT_RESET = 16'd1023;

   // Operation codes
   localparam logic OP_BUILD  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_UNBUILT = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [15:0] query_index;
   } req_type;

   typedef struct packed {
      logic       is_prime;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_BASE_CHECK,
      ST_BASE_TEST,
      ST_STRIKE,
      ST_BUILD_DONE,
      ST_LOOKUP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept_build;
      logic accept_lookup;
      logic fill_step;
      logic base_init;
      logic base_read;
      logic base_next;
      logic strike_init;
      logic strike_step;
      logic finish_build;
      logic load_rsp_build;
      logic load_rsp_lookup;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic fill_last;
      logic base_over;
      logic base_prime;
      logic strike_over;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== rtl/pse_ctrl.sv =====
// Sequencing state machine of the prime sieve engine.
// Depends on pse_pkg; drives the datapath through cmd_type, reads stat_type.
module pse_ctrl
   import pse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_operation,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_LOOKUP) begin
                  cmd.accept_lookup = 1'b1;
                  state_in          = ST_LOOKUP;
               end else begin
                  cmd.accept_build = 1'b1;
                  state_in         = ST_FILL;
               end
            end
         end
         // mark 0..limit, one entry a cycle
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               cmd.base_init = 1'b1;
               state_in      = ST_BASE_CHECK;
            end
         end
         // stop once base squared passes the limit, else fetch its entry
         ST_BASE_CHECK: begin
            if (stat.base_over) begin
               cmd.finish_build = 1'b1;
               state_in         = ST_BUILD_DONE;
            end else begin
               cmd.base_read = 1'b1;
               state_in      = ST_BASE_TEST;
            end
         end
         ST_BASE_TEST: begin
            if (stat.base_prime) begin
               cmd.strike_init = 1'b1;
               state_in        = ST_STRIKE;
            end else begin
               cmd.base_next = 1'b1;
               state_in      = ST_BASE_CHECK;
            end
         end
         // clear multiples from base squared upwards
         ST_STRIKE: begin
            if (stat.strike_over) begin
               cmd.base_next = 1'b1;
               state_in      = ST_BASE_CHECK;
            end else begin
               cmd.strike_step = 1'b1;
            end
         end
         ST_BUILD_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp_build = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp_lookup = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pse_datapath.sv =====
// Datapath of the prime sieve engine: bitmap memory, limit register,
// sieve counters and response register. Depends on pse_pkg.
module pse_datapath
   import pse_pkg::*;
#(
   parameter int MAX_LIMIT = LIMIT_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data,
   input  req_type     req_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  cmd_type     cmd,
   output stat_type    stat
);

   localparam int LIM_CAP = (MAX_LIMIT > INDEX_MAX) ? INDEX_MAX : MAX_LIMIT;
   localparam int DEPTH   = LIM_CAP + 1;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int J_W     = ADDR_W + 1;

   logic [15:0]       sieve_limit_ff, sieve_limit_in;
   logic [ADDR_W-1:0] lim_ff, lim_in;
   logic              built_flag_ff, built_flag_in;
   logic [ADDR_W-1:0] built_limit_ff, built_limit_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [J_W-1:0]    sq_ff, sq_in;
   logic [J_W-1:0]    j_ff, j_in;
   logic [1:0]        lk_status_ff, lk_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              mem [DEPTH];
   logic              rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_data;
   logic [ADDR_W-1:0] eff_limit;

   // Effective limit: register value saturated to the bitmap size
   assign eff_limit = (32'(sieve_limit_ff) > LIM_CAP) ? ADDR_W'(LIM_CAP)
                                                       : sieve_limit_ff[ADDR_W-1:0];

   // Memory ports
   assign rd_addr = cmd.accept_lookup ? req_data.query_index[ADDR_W-1:0] : base_ff;
   assign wr_en   = cmd.fill_step | cmd.strike_step;
   assign wr_addr = j_ff[ADDR_W-1:0];
   assign wr_data = cmd.fill_step & (j_ff >= J_W'(2));

   // read only on a lookup or a base fetch; the bit is held until the next one
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.accept_lookup | cmd.base_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Status to the controller
   assign stat.fill_last   = (j_ff == J_W'(lim_ff));
   assign stat.base_over   = (sq_ff > J_W'(lim_ff));
   assign stat.base_prime  = rd_data_ff;
   assign stat.strike_over = (j_ff > J_W'(lim_ff));
   assign stat.rsp_busy    = rsp_valid_ff & ~rsp_ready;

   // Next values
   always_comb begin
      sieve_limit_in = sieve_limit_ff;
      lim_in         = lim_ff;
      built_flag_in  = built_flag_ff;
      built_limit_in = built_limit_ff;
      base_in        = base_ff;
      sq_in          = sq_ff;
      j_in           = j_ff;
      lk_status_in   = lk_status_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;

      if (csr_write_en) begin
         sieve_limit_in = csr_write_data;
      end

      // build request: latch limit, start fill at zero
      if (cmd.accept_build) begin
         lim_in = eff_limit;
         j_in   = '0;
      end

      // lookup request: work out status now, bit comes from the read
      if (cmd.accept_lookup) begin
         if (!built_flag_ff) begin
            lk_status_in = STATUS_UNBUILT;
         end else if (req_data.query_index > 16'(built_limit_ff)) begin
            lk_status_in = STATUS_RANGE;
         end else begin
            lk_status_in = STATUS_OK;
         end
      end

      if (cmd.fill_step) begin
         j_in = j_ff + J_W'(1);
      end

      if (cmd.base_init) begin
         base_in = ADDR_W'(2);
         sq_in   = J_W'(4);
      end

      // (i+1)^2 = i^2 + 2i + 1
      if (cmd.base_next) begin
         base_in = base_ff + ADDR_W'(1);
         sq_in   = sq_ff + {base_ff, 1'b1};
      end

      if (cmd.strike_init) begin
         j_in = sq_ff;
      end

      if (cmd.strike_step) begin
         j_in = j_ff + J_W'(base_ff);
      end

      if (cmd.finish_build) begin
         built_flag_in  = 1'b1;
         built_limit_in = lim_ff;
      end

      // response register
      if (cmd.load_rsp_build) begin
         rsp_in.is_prime = 1'b0;
         rsp_in.status   = STATUS_OK;
         rsp_valid_in    = 1'b1;
      end else if (cmd.load_rsp_lookup) begin
         rsp_in.is_prime = (lk_status_ff == STATUS_OK) & rd_data_ff;
         rsp_in.status   = lk_status_ff;
         rsp_valid_in    = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sieve_limit_ff <= SIEVE_LIMIT_RESET;
         built_flag_ff  <= 1'b0;
         built_limit_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sieve_limit_ff <= sieve_limit_in;
         built_flag_ff  <= built_flag_in;
         built_limit_ff <= built_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload and counter registers
   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      base_ff      <= base_in;
      sq_ff        <= sq_in;
      j_ff         <= j_in;
      lk_status_ff <= lk_status_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/prime_sieve_engine.sv =====
// Top level of the prime sieve engine: request/response channels and limit register.
// Depends on pse_pkg, pse_ctrl and pse_datapath.
//
// Builds a primality bitmap over 0..L by the Sieve of Eratosthenes, L being
// the limit register saturated to MAX_LIMIT (and to 65535), then answers
// lookups from it. The bitmap is a 1-bit memory with separate read and write
// ports and min(MAX_LIMIT,65535)+1 entries, with one write and one registered
// read per cycle; a build walks it one entry a cycle. A build request first
// marks the entries 0..L, then reads the entry of each base i with i*i <= L,
// and for each prime base p strikes its multiples from p*p up to L, then
// finishes and loads its response. A lookup reads its entry, then loads the
// response register once that register is free; a new request is taken only
// after the last response has been loaded. A finished response waits in its
// output register while the next request is taken. Write the limit only
// while the block is idle.
module prime_sieve_engine
   import pse_pkg::*;
#(
   parameter int MAX_LIMIT = LIMIT_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   pse_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Bitmap, counters and response register
   pse_datapath #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_data       (req_data),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule
